>>> rtl/dnn_pkg.sv
// Package for the directional nearest neighbour search: payload, stage types and constants.
`default_nettype none

package dnn_pkg;

  // Fixed field widths
  localparam int COORD_W  = 16;
  localparam int CENTRE_W = COORD_W + 2;
  localparam int DELTA_W  = CENTRE_W + 1;
  localparam int SQ_W     = 34;
  localparam int DIST_W   = SQ_W + 1;
  localparam int INDEX_W  = 10;

  // Candidate limit and the count that can hold it
  localparam int MAX_CANDIDATES = 1024;
  localparam int COUNT_W        = $clog2(MAX_CANDIDATES + 1);

  // Distances at or above this bound are never chosen
  localparam logic [SQ_W-1:0] DIST_LIMIT = 34'd10000000000;

  // Item commands
  localparam logic CMD_BEGIN     = 1'b0;
  localparam logic CMD_CANDIDATE = 1'b1;

  // Search directions
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  typedef struct packed {
    logic                       cmd;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic        [COORD_W-1:0]  rect_width;
    logic        [COORD_W-1:0]  rect_height;
    logic        [1:0]          direction;
    logic                       active_ok;
    logic                       last;
  } in_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] window_index;
  } out_t;

  // Stage after centre compare: deltas and qualification
  typedef struct packed {
    logic                      is_begin;
    logic                      last;
    logic                      horiz;
    logic                      qual;
    logic [INDEX_W-1:0]        pos;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
  } delta_t;

  // Stage after squaring
  typedef struct packed {
    logic               is_begin;
    logic               last;
    logic               horiz;
    logic               qual;
    logic [INDEX_W-1:0] pos;
    logic [SQ_W-1:0]    sx;
    logic [SQ_W-1:0]    sy;
  } square_t;

endpackage

`default_nettype wire

>>> rtl/directional_nearest_neighbour_top.sv
// Directional nearest neighbour search: three-stage pipeline with running best.
// A result is registered at the output after its last item passes the s1 and s2 registers.
// Throughput: one item per cycle; input stalls only while a finished result
// waits at the output and another last item has reached the final stage.
// Reset clears the query, the running best, the pipeline and the output.
`default_nettype none

module directional_nearest_neighbour_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dnn_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output dnn_pkg::out_t      out_data
);

  import dnn_pkg::*;

  // Query state
  logic signed [CENTRE_W-1:0] centre_x, centre_x_next;
  logic signed [CENTRE_W-1:0] centre_y, centre_y_next;
  logic [1:0]                 query_direction, query_direction_next;
  logic                       query_valid, query_valid_next;
  logic [COUNT_W-1:0]         candidate_count, candidate_count_next;

  // Running best
  logic [SQ_W-1:0]    best_distance, best_distance_next;
  logic [INDEX_W-1:0] best_position, best_position_next;
  logic               have_best, have_best_next;

  // Pipeline stages
  logic    v1, v2;
  delta_t  s1, s1_next;
  square_t s2, s2_next;

  logic advance;
  logic in_fire;

  logic signed [CENTRE_W-1:0] cx, cy;
  logic signed [DELTA_W-1:0]  dx, dy;
  logic                       side;
  logic                       slot_free;

  logic signed [2*DELTA_W-1:0] sq_x_full, sq_y_full;

  logic [DIST_W-1:0]  weighted;
  logic               better;
  logic [SQ_W-1:0]    upd_distance;
  logic [INDEX_W-1:0] upd_position;
  logic               upd_have;
  out_t               result;

  // Stall only when a result must be written but the output still holds one
  assign advance  = !(out_valid && !out_ready && v2 && s2.last);
  assign in_ready = advance;
  assign in_fire  = in_valid && in_ready;

  // Stage 1: centres, deltas, side test and candidate numbering
  always_comb begin
    cx = {{2{in_data.pos_x[COORD_W-1]}}, in_data.pos_x}
       + {2'b00, 1'b0, in_data.rect_width[COORD_W-1:1]};
    cy = {{2{in_data.pos_y[COORD_W-1]}}, in_data.pos_y}
       + {2'b00, 1'b0, in_data.rect_height[COORD_W-1:1]};
    dx = {cx[CENTRE_W-1], cx} - {centre_x[CENTRE_W-1], centre_x};
    dy = {cy[CENTRE_W-1], cy} - {centre_y[CENTRE_W-1], centre_y};
    unique case (query_direction)
      DIR_LEFT:  side = dx[DELTA_W-1];
      DIR_RIGHT: side = !dx[DELTA_W-1] && (dx != '0);
      DIR_DOWN:  side = !dy[DELTA_W-1] && (dy != '0);
      DIR_UP:    side = dy[DELTA_W-1];
      default:   side = 1'b0;
    endcase
    slot_free = candidate_count < COUNT_W'(MAX_CANDIDATES);

    centre_x_next        = centre_x;
    centre_y_next        = centre_y;
    query_direction_next = query_direction;
    query_valid_next     = query_valid;
    candidate_count_next = candidate_count;

    s1_next.is_begin = (in_data.cmd == CMD_BEGIN);
    s1_next.last     = in_data.last;
    s1_next.horiz    = !query_direction[1];
    s1_next.qual     = 1'b0;
    s1_next.pos      = INDEX_W'(candidate_count);
    s1_next.dx       = dx;
    s1_next.dy       = dy;

    if (in_data.cmd == CMD_BEGIN) begin
      centre_x_next        = cx;
      centre_y_next        = cy;
      query_direction_next = in_data.direction;
      query_valid_next     = in_data.active_ok;
      candidate_count_next = '0;
    end else if (slot_free) begin
      candidate_count_next = candidate_count + COUNT_W'(1);
      s1_next.qual         = query_valid && side;
    end

    // Close the query on its last item
    if (in_data.last) begin
      query_valid_next     = 1'b0;
      candidate_count_next = '0;
    end
  end

  // Stage 2: squares of the deltas
  assign sq_x_full = s1.dx * s1.dx;
  assign sq_y_full = s1.dy * s1.dy;

  always_comb begin
    s2_next.is_begin = s1.is_begin;
    s2_next.last     = s1.last;
    s2_next.horiz    = s1.horiz;
    s2_next.qual     = s1.qual;
    s2_next.pos      = s1.pos;
    s2_next.sx       = sq_x_full[SQ_W-1:0];
    s2_next.sy       = sq_y_full[SQ_W-1:0];
  end

  // Stage 3: weighted distance, compare with running best, result
  always_comb begin
    if (s2.horiz) begin
      weighted = {1'b0, s2.sx} + {s2.sy, 1'b0};
    end else begin
      weighted = {s2.sx, 1'b0} + {1'b0, s2.sy};
    end
    better = s2.qual && (weighted < {1'b0, best_distance});

    upd_distance = best_distance;
    upd_position = best_position;
    upd_have     = have_best;
    if (s2.is_begin) begin
      upd_distance = DIST_LIMIT;
      upd_position = '0;
      upd_have     = 1'b0;
    end else if (better) begin
      upd_distance = weighted[SQ_W-1:0];
      upd_position = s2.pos;
      upd_have     = 1'b1;
    end

    result.found        = upd_have;
    result.window_index = upd_have ? upd_position : '0;

    best_distance_next = upd_distance;
    best_position_next = upd_position;
    have_best_next     = upd_have;
    if (s2.last) begin
      best_distance_next = DIST_LIMIT;
      best_position_next = '0;
      have_best_next     = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x        <= '0;
      centre_y        <= '0;
      query_direction <= DIR_LEFT;
      query_valid     <= 1'b0;
      candidate_count <= '0;
      best_distance   <= DIST_LIMIT;
      best_position   <= '0;
      have_best       <= 1'b0;
      v1              <= 1'b0;
      v2              <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (in_fire) begin
        centre_x        <= centre_x_next;
        centre_y        <= centre_y_next;
        query_direction <= query_direction_next;
        query_valid     <= query_valid_next;
        candidate_count <= candidate_count_next;
      end
      if (advance) begin
        v1 <= in_fire;
        v2 <= v1;
        if (v2) begin
          best_distance <= best_distance_next;
          best_position <= best_position_next;
          have_best     <= have_best_next;
        end
      end
      if (advance && v2 && s2.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (advance) begin
      s1 <= s1_next;
      s2 <= s2_next;
      if (v2 && s2.last) begin
        out_data <= result;
      end
    end
  end

  // Input holds off only while a result is blocked at the output
  assert property (@(posedge clk) disable iff (rst) !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  // No result reports a position without a find
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.found) |-> (out_data.window_index == '0))
    else $error("window index set without a find");

  // Without a best, the best registers sit at their cleared values
  assert property (@(posedge clk) disable iff (rst)
    !have_best |-> ((best_distance == DIST_LIMIT) && (best_position == '0)))
    else $error("best registers not cleared");

  // The running best never rises above the limit
  assert property (@(posedge clk) disable iff (rst) best_distance <= DIST_LIMIT)
    else $error("best distance above limit");

endmodule

`default_nettype wire
